// File: hdl/sntp_osel_pkg.sv
package sntp_osel_pkg;

    localparam int unsigned LOCAL_NS_W   = 63;
    localparam int unsigned NS_W         = 64;
    localparam int unsigned SEC_W        = 32;
    localparam int unsigned FRAC_W       = 32;
    localparam int unsigned STRATUM_W    = 8;
    localparam int unsigned NS_PER_SEC_W = 30;
    localparam int unsigned PROD_W       = SEC_W + NS_PER_SEC_W;
    localparam int unsigned RTT_W        = NS_W - 1;
    localparam int unsigned HALF_RTT_W   = RTT_W - 1;

    localparam logic [SEC_W-1:0]        NTP_EPOCH_SHIFT = 32'd2208988800;
    localparam logic [NS_PER_SEC_W-1:0] NS_PER_SEC      = 30'd1000000000;

    typedef struct packed {
        logic [LOCAL_NS_W-1:0] local_send_ns;
        logic [LOCAL_NS_W-1:0] local_recv_ns;
        logic [SEC_W-1:0]      server_recv_seconds;
        logic [FRAC_W-1:0]     server_recv_fraction;
        logic [SEC_W-1:0]      server_send_seconds;
        logic [FRAC_W-1:0]     server_send_fraction;
        logic [STRATUM_W-1:0]  stratum_level;
        logic                  reply_valid;
        logic                  last_sample;
    } sample_t;

    typedef struct packed {
        logic signed [NS_W-1:0] clock_offset_ns;
        logic [HALF_RTT_W-1:0]  half_round_trip_ns;
        logic                   found;
    } result_t;

    // Products of the timestamp conversion.
    typedef struct packed {
        logic [LOCAL_NS_W-1:0] t1;
        logic [LOCAL_NS_W-1:0] t4;
        logic [PROD_W-1:0]     recv_sec_prod;
        logic [PROD_W-1:0]     recv_frac_prod;
        logic [PROD_W-1:0]     send_sec_prod;
        logic [PROD_W-1:0]     send_frac_prod;
        logic                  usable;
        logic                  last;
    } prod_t;

    // All four timestamps in nanoseconds.
    typedef struct packed {
        logic [LOCAL_NS_W-1:0] t1;
        logic [LOCAL_NS_W-1:0] t4;
        logic [NS_W-1:0]       t2;
        logic [NS_W-1:0]       t3;
        logic                  usable;
        logic                  last;
    } stamps_t;

    // Offset sum before halving and the clamped round trip.
    typedef struct packed {
        logic [NS_W-1:0]  offset_sum;
        logic [RTT_W-1:0] round_trip;
        logic             usable;
        logic             last;
    } delay_t;

endpackage

// File: hdl/sntp_osel_conv.sv
module sntp_osel_conv (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  sntp_osel_pkg::sample_t in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output sntp_osel_pkg::stamps_t out_data
);

    logic                   prod_valid_reg;
    sntp_osel_pkg::prod_t   prod_reg;
    sntp_osel_pkg::prod_t   prod_next;
    logic                   prod_ready;
    logic                   ns_valid_reg;
    sntp_osel_pkg::stamps_t ns_reg;
    sntp_osel_pkg::stamps_t ns_next;
    logic [sntp_osel_pkg::SEC_W-1:0] recv_sec;
    logic [sntp_osel_pkg::SEC_W-1:0] send_sec;
    logic [sntp_osel_pkg::PROD_W-1:0] ns_per_sec_ext;
    logic [sntp_osel_pkg::PROD_W-1:0] recv_sec_ext;
    logic [sntp_osel_pkg::PROD_W-1:0] send_sec_ext;
    logic [sntp_osel_pkg::PROD_W-1:0] recv_frac_ext;
    logic [sntp_osel_pkg::PROD_W-1:0] send_frac_ext;

    assign in_ready   = !prod_valid_reg || prod_ready;
    assign prod_ready = !ns_valid_reg || out_ready;
    assign out_valid  = ns_valid_reg;
    assign out_data   = ns_reg;

    // Seconds move from the 1900 epoch to the 1970 epoch with 32-bit wrap.
    assign recv_sec = in_data.server_recv_seconds - sntp_osel_pkg::NTP_EPOCH_SHIFT;
    assign send_sec = in_data.server_send_seconds - sntp_osel_pkg::NTP_EPOCH_SHIFT;

    assign ns_per_sec_ext = {{(sntp_osel_pkg::PROD_W - sntp_osel_pkg::NS_PER_SEC_W){1'b0}},
                             sntp_osel_pkg::NS_PER_SEC};
    assign recv_sec_ext   = {{(sntp_osel_pkg::PROD_W - sntp_osel_pkg::SEC_W){1'b0}}, recv_sec};
    assign send_sec_ext   = {{(sntp_osel_pkg::PROD_W - sntp_osel_pkg::SEC_W){1'b0}}, send_sec};
    assign recv_frac_ext  = {{(sntp_osel_pkg::PROD_W - sntp_osel_pkg::FRAC_W){1'b0}},
                             in_data.server_recv_fraction};
    assign send_frac_ext  = {{(sntp_osel_pkg::PROD_W - sntp_osel_pkg::FRAC_W){1'b0}},
                             in_data.server_send_fraction};

    always_comb begin
        prod_next.t1             = in_data.local_send_ns;
        prod_next.t4             = in_data.local_recv_ns;
        prod_next.recv_sec_prod  = recv_sec_ext * ns_per_sec_ext;
        prod_next.recv_frac_prod = recv_frac_ext * ns_per_sec_ext;
        prod_next.send_sec_prod  = send_sec_ext * ns_per_sec_ext;
        prod_next.send_frac_prod = send_frac_ext * ns_per_sec_ext;
        prod_next.usable         = in_data.reply_valid && (in_data.stratum_level != '0);
        prod_next.last           = in_data.last_sample;
    end

    always_comb begin
        ns_next.t1     = prod_reg.t1;
        ns_next.t4     = prod_reg.t4;
        ns_next.t2     = {2'b00, prod_reg.recv_sec_prod}
                       + {{(sntp_osel_pkg::NS_W - sntp_osel_pkg::NS_PER_SEC_W){1'b0}},
                          prod_reg.recv_frac_prod[sntp_osel_pkg::PROD_W-1:sntp_osel_pkg::FRAC_W]};
        ns_next.t3     = {2'b00, prod_reg.send_sec_prod}
                       + {{(sntp_osel_pkg::NS_W - sntp_osel_pkg::NS_PER_SEC_W){1'b0}},
                          prod_reg.send_frac_prod[sntp_osel_pkg::PROD_W-1:sntp_osel_pkg::FRAC_W]};
        ns_next.usable = prod_reg.usable;
        ns_next.last   = prod_reg.last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            ns_valid_reg   <= 1'b0;
        end else begin
            if (in_ready) begin
                prod_valid_reg <= in_valid;
            end
            if (prod_ready) begin
                ns_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            prod_reg <= prod_next;
        end
        if (prod_ready && prod_valid_reg) begin
            ns_reg <= ns_next;
        end
    end

endmodule

// File: hdl/sntp_osel_delay.sv
module sntp_osel_delay (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  sntp_osel_pkg::stamps_t in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output sntp_osel_pkg::delay_t  out_data
);

    logic                         valid_reg;
    sntp_osel_pkg::delay_t        delay_reg;
    sntp_osel_pkg::delay_t        delay_next;
    logic [sntp_osel_pkg::NS_W-1:0] t1_ext;
    logic [sntp_osel_pkg::NS_W-1:0] t4_ext;
    logic [sntp_osel_pkg::NS_W-1:0] rtt_raw;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = delay_reg;

    assign t1_ext  = {1'b0, in_data.t1};
    assign t4_ext  = {1'b0, in_data.t4};
    assign rtt_raw = (t4_ext - t1_ext) - (in_data.t3 - in_data.t2);

    always_comb begin
        delay_next.offset_sum = (in_data.t2 - t1_ext) + (in_data.t3 - t4_ext);
        // A negative round trip counts as zero.
        delay_next.round_trip = rtt_raw[sntp_osel_pkg::NS_W-1] ?
                                '0 : rtt_raw[sntp_osel_pkg::RTT_W-1:0];
        delay_next.usable     = in_data.usable;
        delay_next.last       = in_data.last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            delay_reg <= delay_next;
        end
    end

endmodule

// File: hdl/sntp_osel_best.sv
module sntp_osel_best (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  sntp_osel_pkg::delay_t  in_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output sntp_osel_pkg::result_t m_payload
);

    logic                                have_sample_reg;
    logic                                have_sample_next;
    logic [sntp_osel_pkg::NS_W-1:0]      kept_offset_reg;
    logic [sntp_osel_pkg::NS_W-1:0]      kept_offset_next;
    logic [sntp_osel_pkg::RTT_W-1:0]     kept_round_trip_reg;
    logic [sntp_osel_pkg::RTT_W-1:0]     kept_round_trip_next;
    logic                                m_valid_reg;
    sntp_osel_pkg::result_t              m_payload_reg;
    sntp_osel_pkg::result_t              m_payload_next;
    logic                                fire;
    logic                                take;
    logic [sntp_osel_pkg::NS_W-1:0]      sum_adj;
    logic [sntp_osel_pkg::NS_W-1:0]      half_offset;

    // A request that does not end a query never waits on the result side.
    assign in_ready  = !in_data.last || !m_valid_reg || m_ready;
    assign fire      = in_valid && in_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // Adding the sign bit before the arithmetic shift rounds toward zero.
    assign sum_adj     = in_data.offset_sum
                       + {{(sntp_osel_pkg::NS_W-1){1'b0}},
                          in_data.offset_sum[sntp_osel_pkg::NS_W-1]};
    assign half_offset = {sum_adj[sntp_osel_pkg::NS_W-1], sum_adj[sntp_osel_pkg::NS_W-1:1]};

    assign take = in_data.usable
                && (!have_sample_reg || (in_data.round_trip < kept_round_trip_reg));

    always_comb begin
        have_sample_next     = have_sample_reg || take;
        kept_offset_next     = take ? half_offset : kept_offset_reg;
        kept_round_trip_next = take ? in_data.round_trip : kept_round_trip_reg;

        m_payload_next.found              = have_sample_next;
        m_payload_next.clock_offset_ns    = have_sample_next ? kept_offset_next : '0;
        m_payload_next.half_round_trip_ns = have_sample_next ?
            kept_round_trip_next[sntp_osel_pkg::RTT_W-1:1] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_sample_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (fire) begin
                have_sample_reg <= in_data.last ? 1'b0 : have_sample_next;
            end
            if (fire && in_data.last) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            kept_offset_reg     <= kept_offset_next;
            kept_round_trip_reg <= kept_round_trip_next;
        end
        if (fire && in_data.last) begin
            m_payload_reg <= m_payload_next;
        end
    end

    a_clear_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_data.last |=> !have_sample_reg)
        else $error("kept sample survived the end of a query");

    a_keep_usable: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !in_data.last && in_data.usable |=> have_sample_reg)
        else $error("usable sample was not kept");

    a_empty_result_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_payload_reg.found |->
            (m_payload_reg.clock_offset_ns == '0) && (m_payload_reg.half_round_trip_ns == '0))
        else $error("result without a usable sample carries nonzero fields");

endmodule

// File: hdl/sntp_offset_min_delay_select_unit.sv
// Channel  Direction  Handshake            Payload
// s_       in         s_valid / s_ready    sntp_osel_pkg::sample_t, one SNTP sample
// m_       out        m_valid / m_ready    sntp_osel_pkg::result_t, one result per query
//
// One request is accepted per cycle while nothing downstream stalls; the pipeline is five registers deep
// (input, products, nanoseconds, offset and round trip, result).
// Only a request that ends a query waits on a held result; other requests pass the result stage without waiting.
// Reset is synchronous on aresetn and empties the pipeline and the kept sample.
module sntp_offset_min_delay_select_unit (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  sntp_osel_pkg::sample_t s_payload,
    output logic                   m_valid,
    input  logic                   m_ready,
    output sntp_osel_pkg::result_t m_payload
);

    logic                   in_valid_reg;
    sntp_osel_pkg::sample_t in_reg;
    logic                   conv_ready;
    logic                   ns_valid;
    logic                   ns_ready;
    sntp_osel_pkg::stamps_t ns_data;
    logic                   delay_valid;
    logic                   delay_ready;
    sntp_osel_pkg::delay_t  delay_data;

    assign s_ready = !in_valid_reg || conv_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_payload;
        end
    end

    sntp_osel_conv u_conv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid_reg),
        .in_ready  (conv_ready),
        .in_data   (in_reg),
        .out_valid (ns_valid),
        .out_ready (ns_ready),
        .out_data  (ns_data)
    );

    sntp_osel_delay u_delay (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ns_valid),
        .in_ready  (ns_ready),
        .in_data   (ns_data),
        .out_valid (delay_valid),
        .out_ready (delay_ready),
        .out_data  (delay_data)
    );

    sntp_osel_best u_best (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (delay_valid),
        .in_ready  (delay_ready),
        .in_data   (delay_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam logic [31:0] EPOCH_1900_TO_1970 = 32'd2208988800;
    localparam logic [63:0] BILLION            = 64'd1000000000;
    localparam logic [62:0] NS63_MAX           = {63{1'b1}};
    localparam logic [31:0] WORD_MAX           = 32'hFFFF_FFFF;
    localparam int          RANDOM_REQUESTS    = 450;
    localparam int          STALL_LIMIT        = 3000;
    localparam int          HOLD_OFF_CYCLES    = 400;
    localparam int          DRAIN_CYCLES       = 16;

    typedef struct {
        sntp_osel_pkg::sample_t smp;
        bit                     typed;
        sntp_osel_pkg::result_t want;
    } table_row_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    sntp_osel_pkg::sample_t s_payload;
    logic                   m_valid;
    logic                   m_ready;
    sntp_osel_pkg::result_t m_payload;

    logic        best_found      = 1'b0;
    logic [63:0] best_offset     = '0;
    logic [63:0] best_round_trip = '0;

    sntp_osel_pkg::result_t pending_results[$];
    table_row_t             request_table[$];
    int                     mismatches     = 0;
    int                     results_taken  = 0;
    bit                     send_calm      = 1'b0;
    int                     send_calm_left = 0;
    bit                     recv_calm      = 1'b0;
    int                     recv_calm_left = 0;

    sntp_offset_min_delay_select_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_payload(s_payload),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_payload(m_payload)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic logic [63:0] ns_from_stamp(input logic [31:0] seconds,
                                                  input logic [31:0] fraction);
        logic [31:0] since_1970;
        since_1970 = seconds - EPOCH_1900_TO_1970;
        return {32'd0, since_1970} * BILLION + (({32'd0, fraction} * BILLION) >> 32);
    endfunction

    // Folds one accepted request into the kept best sample; returns 1 when it closes a query.
    function automatic bit fold_sample(input sntp_osel_pkg::sample_t smp,
                                       output sntp_osel_pkg::result_t res);
        logic [63:0] t1;
        logic [63:0] t2;
        logic [63:0] t3;
        logic [63:0] t4;
        logic [63:0] sum;
        logic [63:0] half;
        logic [63:0] trip;
        t1  = {1'b0, smp.local_send_ns};
        t4  = {1'b0, smp.local_recv_ns};
        res = '0;
        if (smp.reply_valid && smp.stratum_level != '0) begin
            t2   = ns_from_stamp(smp.server_recv_seconds, smp.server_recv_fraction);
            t3   = ns_from_stamp(smp.server_send_seconds, smp.server_send_fraction);
            sum  = (t2 - t1) + (t3 - t4);
            half = sum[63] ? 64'd0 - ((64'd0 - sum) >> 1) : sum >> 1;
            trip = (t4 - t1) - (t3 - t2);
            if (trip[63]) begin
                trip = '0;
            end
            if (!best_found || trip < best_round_trip) begin
                best_found      = 1'b1;
                best_offset     = half;
                best_round_trip = trip;
            end
        end
        if (!smp.last_sample) begin
            return 1'b0;
        end
        res.clock_offset_ns    = best_offset;
        res.half_round_trip_ns = best_round_trip[62:1];
        res.found              = best_found;
        best_found      = 1'b0;
        best_offset     = '0;
        best_round_trip = '0;
        return 1'b1;
    endfunction

    function automatic sntp_osel_pkg::sample_t make_sample(input logic [62:0] t1,
                                                           input logic [62:0] t4,
                                                           input logic [31:0] recv_sec,
                                                           input logic [31:0] recv_frac,
                                                           input logic [31:0] send_sec,
                                                           input logic [31:0] send_frac,
                                                           input logic [7:0] stratum,
                                                           input logic valid,
                                                           input logic last);
        sntp_osel_pkg::sample_t smp;
        smp.local_send_ns        = t1;
        smp.local_recv_ns        = t4;
        smp.server_recv_seconds  = recv_sec;
        smp.server_recv_fraction = recv_frac;
        smp.server_send_seconds  = send_sec;
        smp.server_send_fraction = send_frac;
        smp.stratum_level        = stratum;
        smp.reply_valid          = valid;
        smp.last_sample          = last;
        return smp;
    endfunction

    function automatic sntp_osel_pkg::result_t make_result(input logic [63:0] offset,
                                                           input logic [61:0] half_trip,
                                                           input logic found);
        sntp_osel_pkg::result_t res;
        res.clock_offset_ns    = offset;
        res.half_round_trip_ns = half_trip;
        res.found              = found;
        return res;
    endfunction

    task automatic add_row(input sntp_osel_pkg::sample_t smp, input bit typed,
                           input sntp_osel_pkg::result_t want);
        table_row_t row;
        row.smp   = smp;
        row.typed = typed;
        row.want  = want;
        request_table.push_back(row);
    endtask

    task automatic draw_wait(inout bit calm, inout int calm_left, output int cycles);
        if (calm_left == 0) begin
            calm      = ($urandom_range(0, 3) == 0);
            calm_left = $urandom_range(8, 40);
        end
        calm_left--;
        cycles = calm ? 0 : $urandom_range(0, 12);
    endtask

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $time, field, got, want);
        mismatches++;
    endtask

    // Entered and left just after a falling edge.
    task automatic offer_request(input sntp_osel_pkg::sample_t smp, input bit typed,
                                 input sntp_osel_pkg::result_t want);
        int                     gap;
        sntp_osel_pkg::result_t predicted;
        draw_wait(send_calm, send_calm_left, gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= smp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (fold_sample(smp, predicted)) begin
            pending_results.push_back(typed ? want : predicted);
        end
        @(negedge aclk);
    endtask

    initial begin : driver
        sntp_osel_pkg::sample_t smp;
        logic [287:0]           noise;
        logic [63:0]            t1;
        logic [63:0]            t2;
        logic [63:0]            t3;
        logic [63:0]            t4;
        logic [63:0]            skew;
        logic [63:0]            span_a;
        logic [63:0]            span_b;
        int                     qlen;
        int                     sent;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_payload = '0;

        add_row(make_sample(63'd0, 63'd0, EPOCH_1900_TO_1970, 32'd0, EPOCH_1900_TO_1970, 32'd0,
                            8'd1, 1'b0, 1'b1),
                1'b1, make_result(64'd0, 62'd0, 1'b0));
        add_row(make_sample(63'd0, 63'd0, EPOCH_1900_TO_1970, 32'd0, EPOCH_1900_TO_1970, 32'd0,
                            8'd0, 1'b1, 1'b1),
                1'b1, make_result(64'd0, 62'd0, 1'b0));
        add_row(make_sample(63'd0, 63'd0, EPOCH_1900_TO_1970, 32'd0, EPOCH_1900_TO_1970, 32'd0,
                            8'd1, 1'b1, 1'b1),
                1'b1, make_result(64'd0, 62'd0, 1'b1));
        add_row(make_sample(63'd0, 63'd0, EPOCH_1900_TO_1970 + 32'd1, 32'd0,
                            EPOCH_1900_TO_1970 + 32'd1, 32'd0, 8'd1, 1'b1, 1'b1),
                1'b1, make_result(64'd1000000000, 62'd0, 1'b1));
        add_row(make_sample(63'd0, 63'd2000000000, EPOCH_1900_TO_1970, 32'd0,
                            EPOCH_1900_TO_1970, 32'd0, 8'd1, 1'b1, 1'b1),
                1'b1, make_result(-64'sd1000000000, 62'd1000000000, 1'b1));
        add_row(make_sample(63'd0, 63'd3, EPOCH_1900_TO_1970, 32'd0, EPOCH_1900_TO_1970, 32'd0,
                            8'd2, 1'b1, 1'b1),
                1'b1, make_result(-64'sd1, 62'd1, 1'b1));
        add_row(make_sample(NS63_MAX, NS63_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX,
                            8'hFF, 1'b1, 1'b0), 1'b0, '0);
        add_row(make_sample(63'd0, NS63_MAX, 32'd0, 32'd0, 32'd0, 32'd0, 8'hFF, 1'b1, 1'b0),
                1'b0, '0);
        add_row(make_sample(NS63_MAX, 63'd0, 32'd0, 32'd0, WORD_MAX, WORD_MAX, 8'd1, 1'b1, 1'b0),
                1'b0, '0);
        add_row(make_sample(63'd5, 63'd5, EPOCH_1900_TO_1970, 32'd0, EPOCH_1900_TO_1970, 32'd0,
                            8'd1, 1'b0, 1'b1), 1'b0, '0);
        add_row(make_sample(63'd100, 63'd200, EPOCH_1900_TO_1970, 32'd0,
                            EPOCH_1900_TO_1970, 32'd0, 8'd3, 1'b1, 1'b0), 1'b0, '0);
        add_row(make_sample(63'd1000, 63'd1100, EPOCH_1900_TO_1970, 32'd0,
                            EPOCH_1900_TO_1970, 32'd0, 8'd3, 1'b1, 1'b0), 1'b0, '0);
        add_row(make_sample(63'd0, 63'd50, EPOCH_1900_TO_1970, 32'd0,
                            EPOCH_1900_TO_1970, 32'd0, 8'd0, 1'b1, 1'b0), 1'b0, '0);
        add_row(make_sample(63'd10, 63'd110, EPOCH_1900_TO_1970, 32'd0,
                            EPOCH_1900_TO_1970, 32'd0, 8'd3, 1'b1, 1'b1), 1'b0, '0);
        add_row(make_sample(63'd0, 63'd1000, EPOCH_1900_TO_1970, 32'd0,
                            EPOCH_1900_TO_1970, 32'd0, 8'd1, 1'b1, 1'b0), 1'b0, '0);
        add_row(make_sample(63'd0, 63'd10, EPOCH_1900_TO_1970, 32'd0,
                            EPOCH_1900_TO_1970, 32'd0, 8'd1, 1'b1, 1'b1), 1'b0, '0);
        add_row(make_sample(63'd0, 63'd0, EPOCH_1900_TO_1970, WORD_MAX,
                            EPOCH_1900_TO_1970, 32'd5, 8'd1, 1'b1, 1'b1), 1'b0, '0);
        add_row(make_sample(63'd0, 63'd0, 32'd0, 32'h8000_0000, 32'd1, 32'd0,
                            8'd1, 1'b1, 1'b1), 1'b0, '0);
        add_row(make_sample(NS63_MAX, NS63_MAX, EPOCH_1900_TO_1970, 32'd0,
                            EPOCH_1900_TO_1970, 32'd0, 8'd1, 1'b1, 1'b1), 1'b0, '0);

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (request_table[i]) begin
            offer_request(request_table[i].smp, request_table[i].typed, request_table[i].want);
        end

        sent = 0;
        while (sent < RANDOM_REQUESTS) begin
            if ($urandom_range(0, 6) == 0) begin
                for (int w = 0; w < 9; w++) begin
                    noise[w*32 +: 32] = $urandom;
                end
                smp = noise[$bits(sntp_osel_pkg::sample_t)-1:0];
                offer_request(smp, 1'b0, '0);
                sent++;
            end else begin
                qlen = $urandom_range(1, 8);
                for (int k = 0; k < qlen; k++) begin
                    smp.server_recv_seconds  = $urandom;
                    smp.server_recv_fraction = $urandom;
                    smp.server_send_seconds  = smp.server_recv_seconds + $urandom_range(0, 1);
                    smp.server_send_fraction = $urandom;
                    t2     = ns_from_stamp(smp.server_recv_seconds, smp.server_recv_fraction);
                    t3     = ns_from_stamp(smp.server_send_seconds, smp.server_send_fraction);
                    skew   = {$urandom, $urandom} >> $urandom_range(8, 63);
                    if ($urandom_range(0, 1) == 1) begin
                        skew = 64'd0 - skew;
                    end
                    span_a = 64'($urandom_range(0, 40));
                    span_b = 64'($urandom_range(0, 40));
                    if ($urandom_range(0, 9) == 0) begin
                        span_b = {$urandom, $urandom} >> $urandom_range(30, 63);
                    end
                    t1 = t2 - skew - span_a;
                    t4 = t3 - skew + span_b;
                    smp.local_send_ns = t1[62:0];
                    smp.local_recv_ns = t4[62:0];
                    smp.stratum_level = ($urandom_range(0, 15) == 0) ? 8'd0
                                                                    : 8'($urandom_range(1, 16));
                    smp.reply_valid   = ($urandom_range(0, 15) != 0);
                    smp.last_sample   = (k == qlen - 1);
                    offer_request(smp, 1'b0, '0);
                    sent++;
                end
            end
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("sntp_offset_min_delay_select_unit verification clean");
        end else begin
            $display("sntp_offset_min_delay_select_unit verification failed");
        end
        $finish;
    end

    // One long hold-off lets results back up until the block stops taking requests.
    initial begin : receiver
        int stall;
        bit pressure_done;
        m_ready       = 1'b0;
        pressure_done = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            draw_wait(recv_calm, recv_calm_left, stall);
            if (!pressure_done && results_taken >= 20) begin
                stall         = HOLD_OFF_CYCLES;
                pressure_done = 1'b1;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin : check_results
        sntp_osel_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_taken++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", m_payload.clock_offset_ns, '0);
            end else begin
                want = pending_results.pop_front();
                if (m_payload.clock_offset_ns !== want.clock_offset_ns) begin
                    report_mismatch("clock_offset_ns", m_payload.clock_offset_ns,
                                    want.clock_offset_ns);
                end
                if (m_payload.half_round_trip_ns !== want.half_round_trip_ns) begin
                    report_mismatch("half_round_trip_ns", 64'(m_payload.half_round_trip_ns),
                                    64'(want.half_round_trip_ns));
                end
                if (m_payload.found !== want.found) begin
                    report_mismatch("found", 64'(m_payload.found), 64'(want.found));
                end
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("sntp_offset_min_delay_select_unit verification failed");
        $finish;
    end

endmodule
